/* src/smc_pkg.sv */
// ----------------------------------------------------------------------------
// smc_pkg: shunt monitor calibration constants
// Widths and fixed numbers shared by the calibration pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package smc_pkg;

	localparam int unsigned SHUNT_W = 32;
	localparam int unsigned AMPS_W  = 16;
	localparam int unsigned STEP_W  = 22;
	localparam int unsigned CAL_W   = 16;

	// limit divider: 81920 * 10^6 needs 37 bits
	localparam int unsigned LIM_NW  = 37;
	localparam int unsigned WANT_W  = 37;
	localparam int unsigned MICRO_W = 20;
	// calibration divider: 5120000000 needs 33 bits
	localparam int unsigned CAL_NW  = 33;
	localparam int unsigned PROD_W  = STEP_W + SHUNT_W;

	localparam logic [SHUNT_W-1:0] SHUNT_DEFAULT = 32'd10000;
	localparam logic [LIM_NW-1:0]  LIM_NUM       = 37'd81920000000;
	localparam logic [MICRO_W-1:0] MICRO_PER_A   = 20'd1000000;
	localparam logic [WANT_W:0]    STEP_ROUND    = 38'd32767;
	localparam int unsigned        STEP_SHIFT    = 15;
	localparam logic [CAL_NW-1:0]  CAL_NUM       = 33'd5120000000;
	localparam logic [CAL_NW-1:0]  CAL_MAX       = 33'd65535;

endpackage

`default_nettype wire

/* src/smc_div_cell.sv */
// ----------------------------------------------------------------------------
// smc_div_cell: one restoring-division cell
// Resolves one quotient bit and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module smc_div_cell #(
	parameter int unsigned NW = 8,
	parameter int unsigned DW = 8,
	parameter int unsigned TW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [NW-1:0] in_num,
	input  wire logic [DW-1:0] in_den,
	input  wire logic [DW-1:0] in_rem,
	input  wire logic [NW-1:0] in_quo,
	input  wire logic [TW-1:0] in_tag,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [NW-1:0]      out_num,
	output logic [DW-1:0]      out_den,
	output logic [DW-1:0]      out_rem,
	output logic [NW-1:0]      out_quo,
	output logic [TW-1:0]      out_tag
);

	logic          valid_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	// shift in the next dividend bit, subtract when the divisor fits
	assign trial    = {in_rem, in_num[NW-1]};
	assign fits     = trial >= {1'b0, in_den};
	assign diff     = trial - {1'b0, in_den};
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_num <= {in_num[NW-2:0], 1'b0};
			out_den <= in_den;
			out_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
			out_quo <= {in_quo[NW-2:0], fits};
			out_tag <= in_tag;
		end
	end

	assign out_valid = valid_q;

endmodule

`default_nettype wire

/* src/smc_div_chain.sv */
// ----------------------------------------------------------------------------
// smc_div_chain: row of division cells
// NW cells in a row, one quotient bit each; one item per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module smc_div_chain #(
	parameter int unsigned NW = 8,
	parameter int unsigned DW = 8,
	parameter int unsigned TW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [NW-1:0] in_num,
	input  wire logic [DW-1:0] in_den,
	input  wire logic [TW-1:0] in_tag,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [NW-1:0]      out_quo,
	output logic [DW-1:0]      out_den,
	output logic [TW-1:0]      out_tag
);

	logic          v_a   [0:NW];
	logic          r_a   [0:NW];
	logic [NW-1:0] num_a [0:NW];
	logic [DW-1:0] den_a [0:NW];
	logic [DW-1:0] rem_a [0:NW];
	logic [NW-1:0] quo_a [0:NW];
	logic [TW-1:0] tag_a [0:NW];

	assign v_a[0]   = in_valid;
	assign in_ready = r_a[0];
	assign num_a[0] = in_num;
	assign den_a[0] = in_den;
	assign rem_a[0] = '0;
	assign quo_a[0] = '0;
	assign tag_a[0] = in_tag;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		smc_div_cell #(.NW(NW), .DW(DW), .TW(TW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_a[i]),
			.in_ready  (r_a[i]),
			.in_num    (num_a[i]),
			.in_den    (den_a[i]),
			.in_rem    (rem_a[i]),
			.in_quo    (quo_a[i]),
			.in_tag    (tag_a[i]),
			.out_valid (v_a[i+1]),
			.out_ready (r_a[i+1]),
			.out_num   (num_a[i+1]),
			.out_den   (den_a[i+1]),
			.out_rem   (rem_a[i+1]),
			.out_quo   (quo_a[i+1]),
			.out_tag   (tag_a[i+1])
		);
	end

	assign r_a[NW]   = out_ready;
	assign out_valid = v_a[NW];
	assign out_quo   = quo_a[NW];
	assign out_den   = den_a[NW];
	assign out_tag   = tag_a[NW];

endmodule

`default_nettype wire

/* src/shunt_monitor_calibration_core.sv */
// ----------------------------------------------------------------------------
// shunt_monitor_calibration_core: current step and calibration word
// Turns a shunt value and a full-scale current request into the monitor's
// current step and calibration register value.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) takes one beat per shunt/current pair; the master
//   stream (m_*) returns exactly one beat per input beat, in order.
//   Throughput: one beat per cycle while m_tready is high. The block is a row of restoring
//   division cells: 37 cells compute the shunt current limit, three
//   registered stages clamp the request, round the step and form the
//   step * shunt product, 33 cells divide the calibration constant, and
//   an output register clamps the word.
//   Every stage holds its own valid bit; a stage takes a new beat when it
//   is empty or its successor takes its beat, so bubbles close up and the
//   input keeps flowing while a finished beat waits at the output.
//   When the receiver stalls, beats pile up behind the output register
//   and s_tready falls only once every stage is full.
//   Reset clears all valid bits; the block keeps no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module shunt_monitor_calibration_core
	import smc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // [31:0] shunt_micro_ohm, [47:32] max_current_amps
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata    // [21:0] current_step_microamps,
	                                    // [37:22] calibration_word, [39:38] zero
);

	logic [SHUNT_W-1:0] shunt_in;
	logic [AMPS_W-1:0]  amps_in;
	logic [SHUNT_W-1:0] shunt_fix;

	// limit divider outputs
	logic               a_valid;
	logic               a_ready;
	logic [LIM_NW-1:0]  a_limit;
	logic [SHUNT_W-1:0] a_shunt;
	logic [AMPS_W-1:0]  a_amps;

	// stage 1: clamped request
	logic               v_s1;
	logic               r_s1;
	logic [WANT_W-1:0]  want_s1;
	logic [SHUNT_W-1:0] shunt_s1;
	logic [35:0]        req_ua;
	logic [WANT_W-1:0]  want_nx;

	// stage 2: current step
	logic               v_s2;
	logic               r_s2;
	logic [STEP_W-1:0]  step_s2;
	logic [SHUNT_W-1:0] shunt_s2;
	logic [WANT_W:0]    round_sum;
	logic [STEP_W-1:0]  step_nx;

	// stage 3: saturated product
	logic               v_s3;
	logic               r_s3;
	logic [CAL_NW-1:0]  prod_s3;
	logic [STEP_W-1:0]  step_s3;
	logic [PROD_W-1:0]  prod_full;

	// calibration divider outputs
	logic               b_valid;
	logic               b_ready;
	logic [CAL_NW-1:0]  b_quo;
	logic [CAL_NW-1:0]  b_den;
	logic [STEP_W-1:0]  b_step;

	// output register
	logic               out_valid_q;
	logic [STEP_W-1:0]  out_step_q;
	logic [CAL_W-1:0]   out_cal_q;
	logic [CAL_W-1:0]   cal_nx;

	function automatic logic [35:0] amps_in_mul(input logic [AMPS_W-1:0] a);
		amps_in_mul = a * MICRO_PER_A;
	endfunction

	assign shunt_in  = s_tdata[31:0];
	assign amps_in   = s_tdata[47:32];
	// zero shunt selects the default value
	assign shunt_fix = (shunt_in == '0) ? SHUNT_DEFAULT : shunt_in;

	smc_div_chain #(.NW(LIM_NW), .DW(SHUNT_W), .TW(AMPS_W)) u_lim_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_num    (LIM_NUM),
		.in_den    (shunt_fix),
		.in_tag    (amps_in),
		.out_valid (a_valid),
		.out_ready (a_ready),
		.out_quo   (a_limit),
		.out_den   (a_shunt),
		.out_tag   (a_amps)
	);

	// zero request takes the limit; otherwise clamp the request to it
	assign req_ua  = 36'(amps_in_mul(a_amps));
	assign want_nx = (a_amps == '0 || {1'b0, req_ua} > a_limit) ? a_limit : {1'b0, req_ua};
	assign a_ready = !v_s1 || r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (a_ready) begin
			v_s1 <= a_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (a_ready && a_valid) begin
			want_s1  <= want_nx;
			shunt_s1 <= a_shunt;
		end
	end

	// round the step up, never below one
	assign round_sum = {1'b0, want_s1} + STEP_ROUND;
	assign step_nx   = (round_sum[WANT_W:STEP_SHIFT] == '0) ? STEP_W'(1)
	                   : round_sum[STEP_SHIFT+STEP_W-1:STEP_SHIFT];
	assign r_s1      = !v_s2 || r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (r_s1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (r_s1 && v_s1) begin
			step_s2  <= step_nx;
			shunt_s2 <= shunt_s1;
		end
	end

	// a product past the numerator range gives quotient zero; saturate it
	assign prod_full = step_s2 * shunt_s2;
	assign r_s2      = !v_s3 || r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (r_s2) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (r_s2 && v_s2) begin
			prod_s3 <= (prod_full[PROD_W-1:CAL_NW] != '0) ? '1 : prod_full[CAL_NW-1:0];
			step_s3 <= step_s2;
		end
	end

	smc_div_chain #(.NW(CAL_NW), .DW(CAL_NW), .TW(STEP_W)) u_cal_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (r_s3),
		.in_num    (CAL_NUM),
		.in_den    (prod_s3),
		.in_tag    (step_s3),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_quo   (b_quo),
		.out_den   (b_den),
		.out_tag   (b_step)
	);

	// clamp the calibration word to 1..65535; divisor is never zero
	always_comb begin
		if (b_quo == '0 || b_den == '0) begin
			cal_nx = CAL_W'(1);
		end else if (b_quo > CAL_MAX) begin
			cal_nx = '1;
		end else begin
			cal_nx = b_quo[CAL_W-1:0];
		end
	end

	assign b_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (b_ready) begin
			out_valid_q <= b_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (b_ready && b_valid) begin
			out_step_q <= b_step;
			out_cal_q  <= cal_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_cal_q, out_step_q};

	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_step_q != '0))
		else $error("current step of zero at output");

	a_cal_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_cal_q != '0))
		else $error("calibration word of zero at output");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register is empty");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: shunt monitor calibration bench
// Streams shunt/current pairs through the core with random gaps and stalls on
// both sides, predicts each step and calibration word, and checks every beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds the calibration results that are still on their way through the core.
class cal_scoreboard;
	logic [21:0] step_q[$];
	logic [15:0] word_q[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// Work out the step and the calibration word for one input beat.
	function void note_input(logic [31:0] shunt_in, logic [15:0] amps);
		logic [63:0] shunt;
		logic [63:0] limit;
		logic [63:0] want;
		logic [63:0] step;
		logic [63:0] cal;
		shunt = {32'd0, shunt_in};
		// zero shunt falls back to the default resistor
		if (shunt == 0) begin
			shunt = smc_pkg::SHUNT_DEFAULT;
		end
		limit = 64'd81920000000 / shunt;
		// zero request takes the shunt limit; any request is clamped to it
		want = (amps != 0) ? {48'd0, amps} * 64'd1000000 : limit;
		if (want > limit) begin
			want = limit;
		end
		step = (want + 64'd32767) >> 15;
		if (step == 0) begin
			step = 1;
		end
		cal = 64'd5120000000 / (step * shunt);
		if (cal == 0) begin
			cal = 1;
		end
		if (cal > 64'd65535) begin
			cal = 64'd65535;
		end
		step_q.push_back(step[21:0]);
		word_q.push_back(cal[15:0]);
	endfunction

	// Compare one output beat against the oldest prediction.
	function void check_result(logic [39:0] data);
		logic [21:0] step_exp;
		logic [15:0] word_exp;
		if (step_q.size() == 0) begin
			$error("unexpected output beat: %h", data);
			errors++;
			return;
		end
		step_exp = step_q.pop_front();
		word_exp = word_q.pop_front();
		if (data[21:0] !== step_exp) begin
			$error("current_step_microamps: expected %0d, got %0d", step_exp, data[21:0]);
			errors++;
		end
		if (data[37:22] !== word_exp) begin
			$error("calibration_word: expected %0d, got %0d", word_exp, data[37:22]);
			errors++;
		end
		if (data[39:38] !== 2'b00) begin
			$error("pad bits: expected 0, got %b", data[39:38]);
			errors++;
		end
	endfunction

	function int pending();
		return step_q.size();
	endfunction
endclass

module tb_top;
	import smc_pkg::*;

	localparam int LATENCY = 74;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // [31:0] shunt_micro_ohm, [47:32] max_current_amps
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [21:0] current_step_microamps, [37:22] calibration_word

	cal_scoreboard sb;
	bit stim_done;

	shunt_monitor_calibration_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(10, 60);
		end
	endfunction

	// Drive one beat at the falling edge and hold it until the core takes it.
	task automatic send_pair(input logic [31:0] shunt, input logic [15:0] amps);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {amps, shunt};
		do begin
			@(posedge clk);
		end while (!s_tready);
		sb.note_input(shunt, amps);
		@(negedge clk);
	endtask

	// Shunt values spread over the decades, so every regime shows up.
	function automatic logic [31:0] rand_shunt();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				return 32'd0;
			end
			1: begin
				return $urandom_range(1, 100);
			end
			2, 3: begin
				return $urandom_range(100, 20000);
			end
			4, 5: begin
				return $urandom_range(20000, 2000000);
			end
			6: begin
				return $urandom_range(2000000, 100000000);
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	function automatic logic [15:0] rand_amps();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 16'd0;
		end else if (r < 6) begin
			return 16'($urandom_range(1, 200));
		end else begin
			return 16'($urandom_range(0, 65535));
		end
	endfunction

	// Output side: random stalls, sample at the rising edge.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (stim_done && sb.pending() == 0) begin
				stall = 0;
			end
			m_tready <= (stall == 0);
			if (stall != 0) begin
				repeat (stall - 1) @(negedge clk);
			end
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
			end
		end
	end

	initial begin
		sb = new();
		stim_done = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, default shunt, zero request, clamps
		send_pair(32'd0, 16'd0);
		send_pair(32'd0, 16'd1);
		send_pair(32'd0, 16'd65535);
		send_pair(32'd1, 16'd0);
		send_pair(32'd1, 16'd65535);
		send_pair(32'd1, 16'd1);
		send_pair(32'hFFFF_FFFF, 16'd0);
		send_pair(32'hFFFF_FFFF, 16'd65535);
		send_pair(32'hFFFF_FFFF, 16'd1);
		send_pair(32'd10000, 16'd8);
		send_pair(32'd10000, 16'd9);
		send_pair(32'd2000, 16'd10);
		send_pair(32'd500, 16'd1);
		send_pair(32'd100, 16'd100);
		send_pair(32'd1000000, 16'd0);
		send_pair(32'hAAAA_AAAA, 16'h5555);
		send_pair(32'h5555_5555, 16'hAAAA);
		send_pair(32'd32768, 16'd3);

		// let the pipe drain completely before the random part
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);

		repeat (400) begin
			send_pair(rand_shunt(), rand_amps());
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;

		while (sb.pending() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

/* sim.f */
src/smc_pkg.sv
src/smc_div_cell.sv
src/smc_div_chain.sv
src/shunt_monitor_calibration_core.sv
bench/tb_top.sv
